FILE: hdl/shr_pkg.sv
// Shared types and constants for the supply headroom regulator.
// No dependencies; imported by every module of the block.
package shr_pkg;

	// Number of supply sources with a setting register
	localparam int SOURCE_COUNT = 4;

	localparam int SRC_W      = 2;
	localparam int READING_W  = 16;
	localparam int SETTING_W  = 6;
	localparam int HEADROOM_W = 17;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 16;

	localparam logic [SETTING_W-1:0]  SETTING_MAX    = 6'd63;
	localparam logic [HEADROOM_W-1:0] HEADROOM_START = 17'h0FFFF;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS = 2'd1;

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_PRESET = 1'b1
	} op_t;

	// One input transaction, unpacked
	typedef struct packed {
		op_t                  operation;
		logic [SRC_W-1:0]     source_index;
		logic                 source_powered;
		logic                 driver_present;
		logic                 laser_enabled;
		logic [READING_W-1:0] supply_reading;
		logic [READING_W-1:0] forward_reading;
		logic                 group_last;
		logic [SETTING_W-1:0] preset_value;
	} item_t;

	// Running group status after the current sample
	typedef struct packed {
		logic [HEADROOM_W-1:0] min_headroom;
		logic                  any_counted;
	} group_t;

	// One result transaction
	typedef struct packed {
		logic                 changed;
		logic [SRC_W-1:0]     result_source;
		logic [SETTING_W-1:0] source_setting;
	} result_t;

endpackage

FILE: hdl/shr_headroom_tracker.sv
// Minimum-headroom tracker for one emitter group.
// Depends on shr_pkg (item_t, group_t, HEADROOM_START).
module shr_headroom_tracker import shr_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,        // item in stage 1 advances this cycle
	input  item_t  item,
	output group_t group      // status including the current item
);

	logic [HEADROOM_W-1:0] min_headroom_q;
	logic                  any_counted_q;
	logic [HEADROOM_W-1:0] diff;
	logic                  counts;
	logic                  lower;
	logic                  sample_en;

	// Headroom of this emitter; bit 16 set means forward exceeds supply
	assign diff   = {1'b0, item.supply_reading} - {1'b0, item.forward_reading};
	assign counts = item.driver_present && item.laser_enabled;
	assign lower  = counts && !diff[HEADROOM_W-1] && (diff < min_headroom_q);

	always_comb begin
		group.min_headroom = lower ? diff : min_headroom_q;
		group.any_counted  = any_counted_q || counts;
	end

	assign sample_en = en && (item.operation == OP_SAMPLE);

	// Group state: cleared after the last sample of a group
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_headroom_q <= HEADROOM_START;
			any_counted_q  <= 1'b0;
		end else if (sample_en) begin
			if (item.group_last) begin
				min_headroom_q <= HEADROOM_START;
				any_counted_q  <= 1'b0;
			end else begin
				min_headroom_q <= group.min_headroom;
				any_counted_q  <= group.any_counted;
			end
		end
	end

endmodule

FILE: hdl/shr_setting_ctrl.sv
// Per-source setting store with preset and the step up/down decision.
// Depends on shr_pkg (item_t, group_t, result_t, SOURCE_COUNT, SETTING_MAX).
module shr_setting_ctrl import shr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,         // item in stage 1 advances this cycle
	input  item_t                 item,
	input  group_t                group,
	input  logic [CFG_DATA_W-1:0] threshold,
	input  logic [CFG_DATA_W-1:0] hysteresis,
	output result_t               result
);

	logic [SETTING_W-1:0]  setting_q [SOURCE_COUNT];
	logic [SETTING_W-1:0]  cur_setting;
	logic [SETTING_W-1:0]  new_setting;
	logic                  src_valid;
	logic                  evaluate;
	logic                  step_dn;
	logic                  step_up;
	logic [HEADROOM_W-1:0] upper_limit;

	// Read the selected source; an index with no entry reads as zero
	always_comb begin
		cur_setting = '0;
		src_valid   = 1'b0;
		for (int i = 0; i < SOURCE_COUNT; i++) begin
			if (int'(item.source_index) == i) begin
				cur_setting = setting_q[i];
				src_valid   = 1'b1;
			end
		end
	end

	assign upper_limit = {1'b0, threshold} + {1'b0, hysteresis};
	assign evaluate    = src_valid && item.source_powered && group.any_counted;
	assign step_dn     = evaluate && (group.min_headroom < {1'b0, threshold})
		&& (cur_setting != '0);
	assign step_up     = evaluate && (group.min_headroom > upper_limit)
		&& (cur_setting != SETTING_MAX);

	// Step the setting by one, saturating at both ends
	always_comb begin
		new_setting = cur_setting;
		if (step_dn)
			new_setting = cur_setting - SETTING_W'(1);
		else if (step_up)
			new_setting = cur_setting + SETTING_W'(1);
	end

	always_comb begin
		result.changed        = step_dn || step_up;
		result.result_source  = item.source_index;
		result.source_setting = new_setting;
	end

	// Store update: preset or end-of-group step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SOURCE_COUNT; i++)
				setting_q[i] <= '0;
		end else if (en) begin
			for (int i = 0; i < SOURCE_COUNT; i++) begin
				if (int'(item.source_index) == i) begin
					if (item.operation == OP_PRESET)
						setting_q[i] <= item.preset_value;
					else if (item.group_last && evaluate)
						setting_q[i] <= new_setting;
				end
			end
		end
	end

endmodule

FILE: hdl/supply_headroom_regulator.sv
// Supply headroom regulator top level: input register, tracker, setting control,
// result register and configuration registers.
// Depends on shr_pkg, shr_headroom_tracker and shr_setting_ctrl.
//
// Usage:
//   s_axis carries one transaction per emitter sample or preset. tuser is the
//   operation (0 sample, 1 preset), tlast marks the last sample of a group.
//   m_axis carries one result per group: changed flag, source and its setting
//   after the step. Presets and samples that are not last give no result.
//   cfg_we/cfg_index/cfg_data write the threshold (index 0) and hysteresis
//   (index 1); other indexes are ignored. Write only while the block is idle.
// Timing:
//   One transaction accepted per cycle while s_axis_tready is high. A transaction
//   is held in the input register, evaluated in one pass of the headroom subtract
//   and threshold compares, and its result is then captured in the result register.
// Reset:
//   arst_n clears the setting store to zero, both registers to zero, the group
//   minimum to 0xFFFF and the counted flag; both valid flags go low.
// Stall:
//   While a result waits on m_axis_tready, samples without a result keep
//   flowing; a second group result holds in the input register and s_axis_tready
//   drops until the waiting result is taken.
module supply_headroom_regulator import shr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// Input stream
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// [1:0] source_index, [2] source_powered, [3] driver_present,
	// [4] laser_enabled, [20:5] supply_reading, [36:21] forward_reading,
	// [42:37] preset_value, [47:43] zero
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	input  logic                  s_axis_tuser,   // [0] operation
	input  logic                  s_axis_tlast,   // group_last
	// Result stream
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [0] changed, [2:1] result_source, [8:3] source_setting, [15:9] zero
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// Configuration writes
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	item_t                 item_in;
	item_t                 item_s1;
	logic                  valid_s1;
	logic                  result_s1;
	logic                  advance_s1;
	group_t                group;
	result_t               result;
	result_t               result_q;
	logic                  out_valid_q;
	logic [CFG_DATA_W-1:0] threshold_q;
	logic [CFG_DATA_W-1:0] hysteresis_q;

	// Unpack the input transaction
	always_comb begin
		item_in.operation       = op_t'(s_axis_tuser);
		item_in.source_index    = s_axis_tdata[1:0];
		item_in.source_powered  = s_axis_tdata[2];
		item_in.driver_present  = s_axis_tdata[3];
		item_in.laser_enabled   = s_axis_tdata[4];
		item_in.supply_reading  = s_axis_tdata[20:5];
		item_in.forward_reading = s_axis_tdata[36:21];
		item_in.preset_value    = s_axis_tdata[42:37];
		item_in.group_last      = s_axis_tlast;
	end

	// Stage 1 advances unless it would produce a result while a waiting result is not taken
	assign result_s1     = valid_s1 && (item_s1.operation == OP_SAMPLE) && item_s1.group_last;
	assign advance_s1    = valid_s1 && (!result_s1 || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_axis_tready)
			valid_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready)
			item_s1 <= item_in;
	end

	shr_headroom_tracker u_tracker (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance_s1),
		.item   (item_s1),
		.group  (group)
	);

	shr_setting_ctrl u_setting (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (advance_s1),
		.item       (item_s1),
		.group      (group),
		.threshold  (threshold_q),
		.hysteresis (hysteresis_q),
		.result     (result)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance_s1 && result_s1)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && result_s1)
			result_q <= result;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_DATA_W - SETTING_W - SRC_W - 1){1'b0}},
		result_q.source_setting, result_q.result_source, result_q.changed};

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q  <= '0;
			hysteresis_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_THRESHOLD:  threshold_q  <= cfg_data;
				CFG_HYSTERESIS: hysteresis_q <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

FILE: hdl/shr_checker.sv
// Port-level checks for the supply headroom regulator, bound to the top level.
// Depends on shr_pkg and supply_headroom_regulator.
module shr_checker import shr_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tvalid,
	input logic                  s_axis_tready,
	input logic                  s_axis_tuser,
	input logic                  s_axis_tlast,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata
);

	// A result appears only after a last-sample transaction was accepted
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast
			&& (s_axis_tuser == OP_SAMPLE), 2))
		else $error("result without a preceding last sample");

	// With the output empty the input never stalls
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with output empty");

	// Result valid holds until taken
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped before transaction");

	// Result payload holds while stalled
	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result payload changed while stalled");

endmodule

bind supply_headroom_regulator shr_checker u_checker (.*);

FILE: dv/supply_headroom_regulator_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for supply_headroom_regulator: directed and random sample groups
// and presets, checked against a behavioral predictor. Depends on shr_pkg and the block RTL.
module supply_headroom_regulator_test;
	import shr_pkg::*;

	// Index with no register behind it
	localparam logic [CFG_IDX_W-1:0] CFG_NO_REGISTER = 2'd3;

	// Predicts group results and checks them in order
	class regulator_scoreboard;
		logic [SETTING_W-1:0]  setting [SOURCE_COUNT];
		logic [HEADROOM_W-1:0] min_headroom;
		bit                    counted;
		logic [15:0]           threshold;
		logic [15:0]           hysteresis;
		result_t               expected_results[$];
		int                    errors;

		function new();
			foreach (setting[i]) setting[i] = '0;
			threshold    = '0;
			hysteresis   = '0;
			min_headroom = HEADROOM_START;
			counted      = 1'b0;
			errors       = 0;
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
			if (idx == CFG_THRESHOLD)
				threshold = value;
			else if (idx == CFG_HYSTERESIS)
				hysteresis = value;
		endfunction

		function int pending();
			return expected_results.size();
		endfunction

		// Update the predicted state with one accepted input transaction
		function void note_transaction(item_t it);
			logic [HEADROOM_W-1:0] diff;
			logic [HEADROOM_W-1:0] upper;
			logic [SETTING_W-1:0]  level;
			result_t               res;
			if (it.operation == OP_PRESET) begin
				if (it.source_index < SOURCE_COUNT)
					setting[it.source_index] = it.preset_value;
				return;
			end
			if (it.driver_present && it.laser_enabled) begin
				// negative headroom never lowers the minimum
				if (it.supply_reading >= it.forward_reading) begin
					diff = {1'b0, it.supply_reading} - {1'b0, it.forward_reading};
					if (diff < min_headroom)
						min_headroom = diff;
				end
				counted = 1'b1;
			end
			if (!it.group_last)
				return;
			res.changed       = 1'b0;
			res.result_source = it.source_index;
			level             = '0;
			upper             = {1'b0, threshold} + {1'b0, hysteresis};
			if (it.source_index < SOURCE_COUNT) begin
				level = setting[it.source_index];
				if (it.source_powered && counted) begin
					if (min_headroom < {1'b0, threshold} && level > 0) begin
						level       = level - SETTING_W'(1);
						res.changed = 1'b1;
					end
					if (min_headroom > upper && level < SETTING_MAX) begin
						level       = level + SETTING_W'(1);
						res.changed = 1'b1;
					end
					setting[it.source_index] = level;
				end
			end
			res.source_setting = level;
			min_headroom = HEADROOM_START;
			counted      = 1'b0;
			expected_results.push_back(res);
		endfunction

		// Compare one result transaction with the oldest expectation
		function void check_result(result_t got);
			result_t exp_res;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result changed %0d source %0d setting %0d", $time,
					got.changed, got.result_source, got.source_setting);
				errors++;
				return;
			end
			exp_res = expected_results.pop_front();
			if (got.changed !== exp_res.changed) begin
				$display("%0t: changed expected %0d actual %0d", $time,
					exp_res.changed, got.changed);
				errors++;
			end
			if (got.result_source !== exp_res.result_source) begin
				$display("%0t: result_source expected %0d actual %0d", $time,
					exp_res.result_source, got.result_source);
				errors++;
			end
			if (got.source_setting !== exp_res.source_setting) begin
				$display("%0t: source_setting expected %0d actual %0d", $time,
					exp_res.source_setting, got.source_setting);
				errors++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                  s_axis_tuser = 1'b0;
	logic                  s_axis_tlast = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b1;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	regulator_scoreboard sb;
	int                  idle_pct  = 0;
	int                  stall_pct = 0;

	supply_headroom_regulator i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Result side backpressure
	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= stall_pct);
	end

	// Result monitor
	always @(posedge clk) begin
		result_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.changed        = m_axis_tdata[0];
			got.result_source  = m_axis_tdata[2:1];
			got.source_setting = m_axis_tdata[8:3];
			sb.check_result(got);
		end
	end

	// Run limit
	initial begin
		#3_000_000;
		$display("supply_headroom_regulator_test: errors");
		$finish;
	end

	// Drive one input transaction, with random gaps ahead of it
	task send_transaction(item_t it);
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= it.operation;
		s_axis_tlast  <= it.group_last;
		s_axis_tdata  <= {5'b0, it.preset_value, it.forward_reading, it.supply_reading,
			it.laser_enabled, it.driver_present, it.source_powered, it.source_index};
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_transaction(it);
		@(negedge clk);
	endtask

	task write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.write_register(idx, value);
		@(negedge clk);
	endtask

	// Stop sending and let every expected result and in-flight preset drain
	task wait_idle();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() > 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function item_t sample_item(logic [SRC_W-1:0] src, logic powered, logic present,
		logic enabled, logic [15:0] supply, logic [15:0] forward, logic last);
		item_t it;
		it.operation       = OP_SAMPLE;
		it.source_index    = src;
		it.source_powered  = powered;
		it.driver_present  = present;
		it.laser_enabled   = enabled;
		it.supply_reading  = supply;
		it.forward_reading = forward;
		it.group_last      = last;
		it.preset_value    = SETTING_W'($urandom_range(63));
		return it;
	endfunction

	function item_t preset_item(logic [SRC_W-1:0] src, logic [SETTING_W-1:0] value);
		item_t it;
		it = sample_item(src, 1'($urandom_range(1)), 1'($urandom_range(1)),
			1'($urandom_range(1)), 16'($urandom), 16'($urandom), 1'($urandom_range(1)));
		it.operation    = OP_PRESET;
		it.preset_value = value;
		return it;
	endfunction

	// Random sample; half of the readings put the headroom around the threshold band
	function item_t random_sample();
		int          kind;
		int          lo;
		int          hi;
		int          target;
		int          fwd;
		logic [15:0] supply;
		logic [15:0] forward;
		kind = $urandom_range(9);
		if (kind <= 1) begin
			supply  = 16'($urandom);
			forward = 16'($urandom);
		end else if (kind <= 6) begin
			lo = int'(sb.threshold) - 4;
			if (lo < 0)
				lo = 0;
			hi = int'(sb.threshold) + int'(sb.hysteresis) + 4;
			if (hi > 65535)
				hi = 65535;
			target  = $urandom_range(hi, lo);
			fwd     = $urandom_range(65535 - target, 0);
			supply  = 16'(fwd + target);
			forward = 16'(fwd);
		end else if (kind == 7) begin
			// forward above supply
			supply  = 16'($urandom_range(65534, 0));
			forward = 16'($urandom_range(65535, int'(supply) + 1));
		end else begin
			supply  = $urandom_range(1) ? 16'hFFFF : 16'h0000;
			forward = $urandom_range(1) ? 16'hFFFF : 16'h0000;
		end
		if ($urandom_range(99) < 80)
			return sample_item(SRC_W'($urandom_range(3)), 1'($urandom_range(1)), 1'b1, 1'b1,
				supply, forward, 1'b0);
		return sample_item(SRC_W'($urandom_range(3)), 1'($urandom_range(1)),
			1'($urandom_range(1)), 1'($urandom_range(1)), supply, forward, 1'b0);
	endfunction

	function logic [SETTING_W-1:0] random_preset_value();
		int pick;
		pick = $urandom_range(9);
		if (pick == 0) return 6'd0;
		if (pick == 1) return 6'd1;
		if (pick == 2) return 6'd62;
		if (pick == 3) return SETTING_MAX;
		return SETTING_W'($urandom_range(63));
	endfunction

	// One group of samples, sometimes preceded or interrupted by a preset
	task send_random_group(inout int sent);
		int    n;
		item_t it;
		if ($urandom_range(9) == 0) begin
			send_transaction(preset_item(SRC_W'($urandom_range(3)), random_preset_value()));
			sent++;
		end
		n = ($urandom_range(7) == 0) ? $urandom_range(12, 6) : $urandom_range(5, 1);
		for (int i = 0; i < n; i++) begin
			if (i > 0 && $urandom_range(19) == 0) begin
				send_transaction(preset_item(SRC_W'($urandom_range(3)),
					random_preset_value()));
				sent++;
			end
			it = random_sample();
			if (i == n - 1) begin
				it.group_last     = 1'b1;
				it.source_powered = ($urandom_range(99) < 85);
			end
			send_transaction(it);
			sent++;
		end
	endtask

	// Register settings per phase, extremes included
	logic [15:0] phase_threshold  [8] = '{16'd0, 16'd65535, 16'd32768, 16'd1000,
		16'd65535, 16'd0, 16'd20000, 16'd300};
	logic [15:0] phase_hysteresis [8] = '{16'd0, 16'd65535, 16'd0, 16'd500,
		16'd0, 16'd65535, 16'd20000, 16'd40};

	initial begin
		int    sent;
		item_t it;
		sb = new();
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part: saturation, boundaries, negative headroom, no-count groups
		write_register(CFG_THRESHOLD, 16'd100);
		write_register(CFG_HYSTERESIS, 16'd50);
		send_transaction(preset_item(2'd0, 6'd0));
		send_transaction(preset_item(2'd1, SETTING_MAX));
		send_transaction(preset_item(2'd2, 6'd30));
		it = preset_item(2'd3, 6'd1);
		it.group_last     = 1'b1;
		it.driver_present = 1'b1;
		it.laser_enabled  = 1'b1;
		send_transaction(it);
		send_transaction(sample_item(2'd0, 1'b1, 1'b1, 1'b1, 16'd110, 16'd100, 1'b1));
		send_transaction(sample_item(2'd1, 1'b1, 1'b1, 1'b1, 16'd300, 16'd100, 1'b1));
		send_transaction(sample_item(2'd2, 1'b1, 1'b1, 1'b1, 16'd60, 16'd50, 1'b1));
		send_transaction(sample_item(2'd2, 1'b1, 1'b1, 1'b1, 16'd351, 16'd200, 1'b1));
		send_transaction(sample_item(2'd2, 1'b1, 1'b1, 1'b1, 16'd250, 16'd100, 1'b1));
		send_transaction(sample_item(2'd2, 1'b1, 1'b1, 1'b1, 16'd100, 16'd0, 1'b1));
		send_transaction(sample_item(2'd2, 1'b1, 1'b1, 1'b1, 16'd0, 16'd65535, 1'b1));
		send_transaction(sample_item(2'd3, 1'b0, 1'b1, 1'b1, 16'd5, 16'd0, 1'b1));
		send_transaction(sample_item(2'd3, 1'b1, 1'b0, 1'b1, 16'd5, 16'd0, 1'b0));
		send_transaction(sample_item(2'd3, 1'b1, 1'b1, 1'b0, 16'd5, 16'd0, 1'b1));
		send_transaction(sample_item(2'd1, 1'b0, 1'b1, 1'b1, 16'd600, 16'd100, 1'b0));
		send_transaction(sample_item(2'd0, 1'b0, 1'b1, 1'b1, 16'd120, 16'd100, 1'b0));
		send_transaction(sample_item(2'd2, 1'b1, 1'b1, 1'b1, 16'd400, 16'd100, 1'b1));
		send_transaction(sample_item(2'd3, 1'b1, 1'b1, 1'b1, 16'd65535, 16'd0, 1'b1));
		send_transaction(sample_item(2'd3, 1'b1, 1'b1, 1'b1, 16'd0, 16'd0, 1'b1));
		send_transaction(sample_item(2'd1, 1'b1, 1'b1, 1'b1, 16'd105, 16'd100, 1'b0));
		send_transaction(preset_item(2'd1, 6'd10));
		send_transaction(sample_item(2'd1, 1'b1, 1'b1, 1'b1, 16'd5000, 16'd0, 1'b1));
		send_transaction(sample_item(2'd0, 1'b1, 1'b1, 1'b1, 16'd65535, 16'd65535, 1'b1));
		wait_idle();

		// Random phases: idle pattern cycles through none, sender, receiver, both
		for (int phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 65; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 65; end
				default: begin idle_pct = 13; stall_pct = 13; end
			endcase
			write_register(CFG_THRESHOLD, phase_threshold[phase]);
			write_register(CFG_HYSTERESIS, phase_hysteresis[phase]);
			// an index past the two registers must be ignored
			if (phase == 3)
				write_register(CFG_NO_REGISTER, CFG_DATA_W'($urandom));
			sent = 0;
			while (sent < 106)
				send_random_group(sent);
			wait_idle();
		end

		repeat (10) @(negedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("supply_headroom_regulator_test: clean");
		else
			$display("supply_headroom_regulator_test: errors");
		$finish;
	end

endmodule
